// ===== hdl/byte_ring_fifo_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the byte ring FIFO core
// Concurrent checks, clocked on the rising edge, off while reset is low.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_CORE_ASSERT_SVH

// Same-cycle implication
`define BRF_ASSERT_IMPL(name, clk_s, rst_n_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BRF_ASSERT_NEXT(name, clk_s, rst_n_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/brf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring FIFO package
// Widths, command codes, controller states and the control/status bundles.
// ---------------------------------------------------------------------------
package brf_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int MAX_BURST_DEF = 64;

	localparam int CFG_W       = 11;
	localparam int CMD_W       = 3;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;
	localparam int OUT_COUNT_W = 11;
	localparam int OUT_INDEX_W = 10;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;
	localparam int S_PAD_W   = S_TDATA_W - (CMD_W + BYTE_W + LEN_W);
	localparam int M_PAD_W   = M_TDATA_W - (BYTE_W + OUT_COUNT_W + OUT_INDEX_W);

	localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SKIP   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CONTIG = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_BURST
	} brf_state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;      // latch the accepted input item
		logic cfg_we;       // write capacity, empty the ring
		logic exec_single;  // load single result, update ring state
		logic burst_start;  // load burst counters from head
		logic issue;        // read one store byte
		logic take;         // move read byte into output register
		logic burst_done;   // last byte of burst moved out
	} brf_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic is_burst;     // captured command delivers bytes
		logic slot_free;    // output register can load this cycle
		logic rd_valid;     // read data register holds a byte
		logic iss_left;     // store reads still to issue
		logic deliver_last; // next byte moved out is the final one
	} brf_sts_t;

endpackage

// ===== hdl/brf_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring FIFO controller
// Sequences capture, single-result execution and byte bursts.
// ---------------------------------------------------------------------------
`include "byte_ring_fifo_core_assert.svh"

module brf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            cfg_valid,
	input  brf_pkg::brf_sts_t sts,
	output logic            idle,
	output brf_pkg::brf_ctl_t ctl
);
	import brf_pkg::*;

	brf_state_t state_q;
	brf_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		idle    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle        = 1'b1;
				ctl.capture = s_tvalid;
				ctl.cfg_we  = cfg_valid;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_burst) begin
					ctl.burst_start = 1'b1;
					state_d         = ST_BURST;
				end else if (sts.slot_free) begin
					ctl.exec_single = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_BURST: begin
				// Keep one read in flight, refill as the output drains
				ctl.take  = sts.rd_valid && sts.slot_free;
				ctl.issue = sts.iss_left && (!sts.rd_valid || ctl.take);
				if (ctl.take && sts.deliver_last) begin
					ctl.burst_done = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`BRF_ASSERT_IMPL(a_idle_no_reads, clk, arst_n, state_q == ST_IDLE, !sts.rd_valid && !sts.iss_left, "reads pending while idle")
	`BRF_ASSERT_NEXT(a_burst_returns_idle, clk, arst_n, ctl.burst_done, idle, "burst end did not return to idle")
	`BRF_ASSERT_IMPL(a_no_issue_outside_burst, clk, arst_n, state_q != ST_BURST, !ctl.issue && !ctl.take, "store read outside burst")

endmodule

// ===== hdl/brf_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring FIFO datapath
// Ring pointers, byte store, burst counters and the output register.
// ---------------------------------------------------------------------------
`include "byte_ring_fifo_core_assert.svh"

module brf_dpath #(
	parameter int DEPTH     = brf_pkg::DEPTH_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  brf_pkg::brf_ctl_t             ctl,
	output brf_pkg::brf_sts_t             sts,
	input  logic [brf_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [brf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [brf_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import brf_pkg::*;

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int SW  = CW + 1;
	localparam int EW0 = (CW > CFG_W) ? CW : CFG_W;
	localparam int EW  = (EW0 > LEN_W) ? EW0 : LEN_W;

	// Captured command
	logic [CMD_W-1:0]  cmd_q;
	logic [BYTE_W-1:0] byte_q;
	logic [LEN_W-1:0]  len_q;

	// Ring state
	logic [CFG_W-1:0] capacity_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    fill_q;

	// Burst state
	logic [AW-1:0]     pos_q;
	logic [LEN_W-1:0]  n_q;
	logic [LEN_W-1:0]  iss_q;
	logic [LEN_W-1:0]  dlv_q;
	logic              rd_valid_q;
	logic [BYTE_W-1:0] rd_data_q;

	// Output register
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic [OUT_COUNT_W-1:0] out_count_q;
	logic [OUT_INDEX_W-1:0] out_index_q;
	logic                   out_last_q;

	logic [BYTE_W-1:0] store [DEPTH];

	logic [CW-1:0]    cap_eff;
	logic             full;
	logic [AW-1:0]    tail_next;
	logic [AW-1:0]    pos_next;
	logic [LEN_W-1:0] len_b;
	logic [LEN_W-1:0] n_burst;
	logic [CW-1:0]    n_skip;
	logic             commit_ok;
	logic [SW-1:0]    adv_sum;
	logic [AW-1:0]    head_adv;
	logic [CW-1:0]    run_raw;
	logic [CW-1:0]    run;
	logic [CW-1:0]    res_count;
	logic [OUT_INDEX_W-1:0] res_index;

	// Effective capacity, clamped to one and the built depth
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (EW'(capacity_q) > EW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = CW'(capacity_q);
		end
	end

	// Pointer arithmetic
	always_comb begin
		full      = fill_q >= cap_eff;
		tail_next = ((CW'(tail_q) + CW'(1)) == cap_eff) ? '0 : tail_q + AW'(1);
		pos_next  = ((CW'(pos_q) + CW'(1)) == cap_eff) ? '0 : pos_q + AW'(1);

		len_b   = (len_q > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : len_q;
		n_burst = (EW'(len_b) > EW'(fill_q)) ? LEN_W'(fill_q) : len_b;

		n_skip    = (EW'(len_q) > EW'(fill_q)) ? fill_q : CW'(len_q);
		commit_ok = (len_q != '0) && (EW'(len_q) <= EW'(fill_q));

		// head + n stays below twice the capacity
		adv_sum  = SW'(head_q) + SW'(n_skip);
		head_adv = (adv_sum >= SW'(cap_eff)) ? AW'(adv_sum - SW'(cap_eff)) : AW'(adv_sum);

		run_raw = cap_eff - CW'(head_q);
		run     = (run_raw > fill_q) ? fill_q : run_raw;
	end

	// Single result fields
	always_comb begin
		res_count = '0;
		res_index = '0;
		case (cmd_q)
			CMD_WRITE: begin
				res_count = full ? '0 : CW'(1);
			end
			CMD_SKIP: begin
				res_count = n_skip;
			end
			CMD_COMMIT: begin
				res_count = commit_ok ? CW'(len_q) : '0;
			end
			CMD_CONTIG: begin
				res_count = run;
				res_index = OUT_INDEX_W'(head_q);
			end
			default: begin
				res_count = '0;
			end
		endcase
	end

	// Capture accepted item
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= s_tdata[CMD_W-1:0];
			byte_q <= s_tdata[CMD_W +: BYTE_W];
			len_q  <= s_tdata[CMD_W+BYTE_W +: LEN_W];
		end
	end

	// Ring state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
		end else if (ctl.cfg_we) begin
			capacity_q <= cfg_data;
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
		end else if (ctl.exec_single) begin
			case (cmd_q)
				CMD_WRITE: begin
					if (!full) begin
						tail_q <= tail_next;
						fill_q <= fill_q + CW'(1);
					end
				end
				CMD_SKIP: begin
					head_q <= head_adv;
					fill_q <= fill_q - n_skip;
				end
				CMD_COMMIT: begin
					if (commit_ok) begin
						head_q <= head_adv;
						fill_q <= fill_q - n_skip;
					end
				end
				CMD_CLEAR: begin
					head_q <= '0;
					tail_q <= '0;
					fill_q <= '0;
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end else if (ctl.burst_done && (cmd_q == CMD_READ)) begin
			head_q <= pos_q;
			fill_q <= fill_q - CW'(n_q);
		end
	end

	// Byte store
	always_ff @(posedge clk) begin
		if (ctl.exec_single && (cmd_q == CMD_WRITE) && !full) begin
			store[tail_q] <= byte_q;
		end
		if (ctl.issue) begin
			rd_data_q <= store[pos_q];
		end
	end

	// Burst counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			n_q        <= '0;
			iss_q      <= '0;
			dlv_q      <= '0;
			rd_valid_q <= 1'b0;
		end else if (ctl.burst_start) begin
			pos_q      <= head_q;
			n_q        <= n_burst;
			iss_q      <= n_burst;
			dlv_q      <= n_burst;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.issue) begin
				pos_q <= pos_next;
				iss_q <= iss_q - LEN_W'(1);
			end
			if (ctl.take) begin
				dlv_q <= dlv_q - LEN_W'(1);
			end
			if (ctl.issue) begin
				rd_valid_q <= 1'b1;
			end else if (ctl.take) begin
				rd_valid_q <= 1'b0;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec_single || ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctl.exec_single) begin
			out_byte_q  <= '0;
			out_count_q <= OUT_COUNT_W'(res_count);
			out_index_q <= res_index;
			out_last_q  <= 1'b1;
		end else if (ctl.take) begin
			out_byte_q  <= rd_data_q;
			out_count_q <= OUT_COUNT_W'(n_q);
			out_index_q <= '0;
			out_last_q  <= (dlv_q == LEN_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_index_q, out_count_q, out_byte_q};
	assign m_tlast  = out_last_q;

	always_comb begin
		sts.is_burst     = ((cmd_q == CMD_READ) || (cmd_q == CMD_PEEK)) && (n_burst != '0);
		sts.slot_free    = !out_valid_q || m_tready;
		sts.rd_valid     = rd_valid_q;
		sts.iss_left     = iss_q != '0;
		sts.deliver_last = dlv_q == LEN_W'(1);
	end

	`BRF_ASSERT_IMPL(a_fill_in_cap, clk, arst_n, 1'b1, fill_q <= cap_eff, "fill count above capacity")
	`BRF_ASSERT_IMPL(a_inflight_one, clk, arst_n, 1'b1, dlv_q == (iss_q + LEN_W'(rd_valid_q)), "burst counters out of step")
	`BRF_ASSERT_IMPL(a_no_overwrite, clk, arst_n, (ctl.exec_single || ctl.take) && out_valid_q, m_tready, "held result overwritten")

endmodule

// ===== hdl/byte_ring_fifo_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring FIFO core
// Command-driven circular byte buffer with a configurable usable size.
// ---------------------------------------------------------------------------
// Commands arrive on the s_ stream (cmd, data_byte, length in s_tdata); each
// command answers on the m_ stream with one or more transfers, m_tlast on the
// final one. Write, skip, commit, clear, contig query and a read or peek that
// finds nothing give one transfer; read and peek give one transfer per byte.
// The capacity register is written on the cfg_ channel while no command is in
// flight; a write empties the ring and keeps the stored bytes.
// Flow: a single-result command is captured, then executed into the output
// register once that register is free. A burst is captured, its counters are
// loaded from head, then each byte is read from the store into the read data
// register and moved out, one byte per cycle while the receiver takes them.
// One command is worked at a time; s_tready is high only between commands,
// and the one store read port with its registered data sets the byte rate.
// A finished result waits in the output register while the next command is
// taken. When the receiver stalls the burst holds, one read stays in flight.
// Reset empties the ring and sets capacity to 1024; store contents are left
// undefined and need no clearing pass.
// ---------------------------------------------------------------------------
module byte_ring_fifo_core #(
	parameter int DEPTH     = brf_pkg::DEPTH_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [2:0] cmd, [10:3] data_byte, [17:11] length, [23:18] zero
	input  logic [brf_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] out_byte, [18:8] out_count, [28:19] out_index, [31:29] zero
	output logic [brf_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [brf_pkg::CFG_W-1:0]     cfg_data
);
	import brf_pkg::*;

	brf_ctl_t ctl;
	brf_sts_t sts;
	logic     idle;

	brf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.cfg_valid (cfg_valid),
		.sts       (sts),
		.idle      (idle),
		.ctl       (ctl)
	);

	brf_dpath #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.cfg_data (cfg_data),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Take commands and register writes only between commands
	assign s_tready  = idle;
	assign cfg_ready = idle;

endmodule
